// ===== hdl/sa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_pkg
// Shared constants, codes and structs of the stack allocator.
// ----------------------------------------------------------------------------
package sa_pkg;

  // Sizes of the pool and of the block stack
  localparam int POOL_MAX     = 65536;
  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 4;
  localparam int ALIGN_MAX    = 6;

  localparam int OFS_W   = 16;                     // payload offset / block start
  localparam int USED_W  = 17;                     // top offset, pool size
  localparam int IDX_W   = $clog2(MAX_BLOCKS);     // stack entry index
  localparam int CNT_W   = IDX_W + 1;              // block count, 0..MAX_BLOCKS
  localparam int ALIGN_W = 3;
  localparam int MASK_W  = ALIGN_MAX + 1;

  // Configuration register indexes
  localparam logic CFG_POOL_BYTES = 1'b0;
  localparam logic CFG_ALIGN_LOG2 = 1'b1;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_NOT_TOP    = 2'd2,
    ST_STACK_FULL = 2'd3
  } status_e;

  // Access to the block start memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [OFS_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // One result
  typedef struct packed {
    status_e           status;
    logic [OFS_W-1:0]  addr_out;
    logic [USED_W-1:0] used_bytes;
  } result_t;

endpackage

// ===== hdl/sa_stack_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_stack_mem
// Block start memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sa_stack_mem (
  input  logic                     clk_i,
  input  sa_pkg::mem_req_t         req_i,
  output logic [sa_pkg::OFS_W-1:0] rdata_o
);

  logic [sa_pkg::OFS_W-1:0] mem_q [sa_pkg::MAX_BLOCKS];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

// ===== hdl/sa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_ctrl
// Allocator state and request decode: top offset, block count, cached top
// block start and configuration registers; drives the block start memory.
// ----------------------------------------------------------------------------
module sa_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [sa_pkg::USED_W-1:0]   cfg_data_i,
  // request
  input  logic                        req_fire_i,
  input  logic [1:0]                  mode_i,
  input  logic [sa_pkg::OFS_W-1:0]    req_size_i,
  input  logic [sa_pkg::OFS_W-1:0]    addr_i,
  output sa_pkg::result_t             result_o,
  output logic                        busy_o,
  // memory
  output sa_pkg::mem_req_t            mem_req_o,
  input  logic [sa_pkg::OFS_W-1:0]    mem_rdata_i
);

  logic [sa_pkg::USED_W-1:0]  pool_q;
  logic [sa_pkg::ALIGN_W-1:0] align_q;

  logic [sa_pkg::USED_W-1:0] top_q, top_d;
  logic [sa_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [sa_pkg::OFS_W-1:0]  tstart_q, tstart_d;
  logic                      fill_q, fill_d;

  logic [sa_pkg::ALIGN_W-1:0] align_eff;
  logic [sa_pkg::MASK_W-1:0]  align_mask;
  logic [sa_pkg::USED_W-1:0]  total;
  logic [sa_pkg::USED_W-1:0]  blk_size;
  logic [sa_pkg::USED_W:0]    end_ofs;
  logic [sa_pkg::USED_W-1:0]  pool_lim;
  logic [sa_pkg::OFS_W-1:0]   top_payload;
  logic [sa_pkg::CNT_W-1:0]   below_top;
  sa_pkg::mode_e              mode;

  assign mode = sa_pkg::mode_e'(mode_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= sa_pkg::USED_W'(sa_pkg::POOL_MAX);
      align_q <= sa_pkg::ALIGN_W'(2);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sa_pkg::CFG_POOL_BYTES) begin
        pool_q <= cfg_data_i;
      end else begin
        align_q <= cfg_data_i[sa_pkg::ALIGN_W-1:0];
      end
    end
  end

  // block size: header added, rounded up to the alignment
  assign align_eff  = (align_q > sa_pkg::ALIGN_W'(sa_pkg::ALIGN_MAX))
                      ? sa_pkg::ALIGN_W'(sa_pkg::ALIGN_MAX) : align_q;
  assign align_mask = (sa_pkg::MASK_W'(1) << align_eff) - sa_pkg::MASK_W'(1);
  assign total      = {1'b0, req_size_i} + sa_pkg::USED_W'(sa_pkg::HEADER_BYTES);
  assign blk_size   = (total + sa_pkg::USED_W'(align_mask))
                      & ~sa_pkg::USED_W'(align_mask);

  // space check against the clamped pool size
  assign pool_lim = (pool_q > sa_pkg::USED_W'(sa_pkg::POOL_MAX))
                    ? sa_pkg::USED_W'(sa_pkg::POOL_MAX) : pool_q;
  assign end_ofs  = {1'b0, top_q} + {1'b0, blk_size};

  assign top_payload = tstart_q + sa_pkg::OFS_W'(sa_pkg::HEADER_BYTES);
  assign below_top   = cnt_q - sa_pkg::CNT_W'(2);

  // request decode and next state
  always_comb begin
    top_d    = top_q;
    cnt_d    = cnt_q;
    tstart_d = tstart_q;
    fill_d   = 1'b0;
    mem_req_o          = '0;
    result_o.status    = sa_pkg::ST_OK;
    result_o.addr_out  = '0;

    // new top entry arrives from memory after a pop
    if (fill_q) begin
      tstart_d = mem_rdata_i;
    end

    if (req_fire_i) begin
      case (mode)
        sa_pkg::MODE_ALLOC: begin
          if (cnt_q >= sa_pkg::CNT_W'(sa_pkg::MAX_BLOCKS)) begin
            result_o.status = sa_pkg::ST_STACK_FULL;
          end else if (end_ofs > {1'b0, pool_lim}) begin
            result_o.status = sa_pkg::ST_NO_SPACE;
          end else begin
            mem_req_o.we      = 1'b1;
            mem_req_o.waddr   = cnt_q[sa_pkg::IDX_W-1:0];
            mem_req_o.wdata   = top_q[sa_pkg::OFS_W-1:0];
            cnt_d             = cnt_q + sa_pkg::CNT_W'(1);
            tstart_d          = top_q[sa_pkg::OFS_W-1:0];
            top_d             = end_ofs[sa_pkg::USED_W-1:0];
            result_o.addr_out = top_q[sa_pkg::OFS_W-1:0]
                                + sa_pkg::OFS_W'(sa_pkg::HEADER_BYTES);
          end
        end
        sa_pkg::MODE_FREE: begin
          if (cnt_q == '0 || top_payload != addr_i) begin
            result_o.status = sa_pkg::ST_NOT_TOP;
          end else begin
            cnt_d = cnt_q - sa_pkg::CNT_W'(1);
            top_d = {1'b0, tstart_q};
            // fetch the block that becomes the top
            if (cnt_q != sa_pkg::CNT_W'(1)) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = below_top[sa_pkg::IDX_W-1:0];
              fill_d          = 1'b1;
            end
          end
        end
        sa_pkg::MODE_CLEAR: begin
          top_d = '0;
          cnt_d = '0;
        end
        default: begin
        end
      endcase
    end

    result_o.used_bytes = top_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      cnt_q  <= '0;
      fill_q <= 1'b0;
    end else begin
      top_q  <= top_d;
      cnt_q  <= cnt_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tstart_q <= tstart_d;
  end

  assign busy_o = fill_q;

endmodule

// ===== hdl/stack_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_allocator
// Stack (bump) allocator over a byte pool with a stack of block starts.
//
// Requests come in on a valid/ready channel (mode, req_size, addr); each one
// gives exactly one result (status, addr_out, used_bytes) on a valid/ready
// output channel. The result sits in an output register and shows up the
// cycle after the request is taken.
// Throughput is one request per cycle when nothing stalls. A free that
// uncovers an older block holds off the next request while the new top
// block start is read from the block start memory (one read port).
// A new request is taken while a result waits only if that result is taken
// in the same cycle; a stalled receiver holds the result and backs up the
// request channel.
// Configuration: cfg_we_i writes pool_bytes (index 0) or align_log2
// (index 1); the user must do so only while the block is idle, as the
// block does not enforce it. Reset empties the pool, sets pool_bytes to
// 65536 and align_log2 to 2; the block start memory needs no clearing.
// ----------------------------------------------------------------------------
module stack_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [sa_pkg::USED_W-1:0] cfg_data_i,
  // requests
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                mode_i,
  input  logic [sa_pkg::OFS_W-1:0]  req_size_i,
  input  logic [sa_pkg::OFS_W-1:0]  addr_i,
  // results
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [sa_pkg::OFS_W-1:0]  addr_out_o,
  output logic [sa_pkg::USED_W-1:0] used_bytes_o
);

  sa_pkg::mem_req_t         mem_req;
  logic [sa_pkg::OFS_W-1:0] mem_rdata;
  sa_pkg::result_t          result;
  logic                     busy;
  logic                     in_fire;

  logic                      out_valid_q;
  logic [1:0]                status_q;
  logic [sa_pkg::OFS_W-1:0]  addr_out_q;
  logic [sa_pkg::USED_W-1:0] used_q;

  assign in_ready_o = !busy && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  sa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_fire_i  (in_fire),
    .mode_i      (mode_i),
    .req_size_i  (req_size_i),
    .addr_i      (addr_i),
    .result_o    (result),
    .busy_o      (busy),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  sa_stack_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q   <= result.status;
      addr_out_q <= result.addr_out;
      used_q     <= result.used_bytes;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign addr_out_o   = addr_out_q;
  assign used_bytes_o = used_q;

  // checks
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("request taken while top block start is being fetched");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted request gave no result");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> used_bytes_o <= sa_pkg::USED_W'(sa_pkg::POOL_MAX))
    else $error("bytes in use exceed the pool");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != sa_pkg::ST_OK) |-> addr_out_o == '0)
    else $error("failed request reports an address");

endmodule

// ===== tb/stack_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_allocator_tb
// Self-checking bench for the stack allocator. A short table of directed
// requests and register writes comes first: pool edges, alignment limits,
// wrong and empty frees, and the payload that wraps at the pool end. Random
// request mixes follow: one at the default geometry, one with no idling
// that fills the block stack until it overflows, then pool/alignment sweeps.
// A shadow allocator predicts every result; elsewhere sides idle at random.
// ----------------------------------------------------------------------------
module stack_allocator_tb;
  import sa_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int IDLE_PCT      = 27;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 200000;

  // DUT inputs start at known values
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_idx_i   = CFG_POOL_BYTES;
  logic [USED_W-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic [1:0]        mode_i      = MODE_NOP;
  logic [OFS_W-1:0]  req_size_i  = '0;
  logic [OFS_W-1:0]  addr_i      = '0;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [1:0]        status_o;
  logic [OFS_W-1:0]  addr_out_o;
  logic [USED_W-1:0] used_bytes_o;

  // Shadow allocator: registers and pool state
  logic [USED_W-1:0]  cfg_pool    = USED_W'(POOL_MAX);
  logic [ALIGN_W-1:0] cfg_align   = 3'd2;
  int unsigned        pool_top    = 0;
  int unsigned        stack_depth = 0;
  int unsigned        block_base [MAX_BLOCKS];

  result_t     awaited_results [$];
  int unsigned n_fail = 0;
  bit          steady = 1'b0;   // no idling on either side while set

  // Directed steps: a request or a register write
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    mode_e             mode;
    logic [OFS_W-1:0]  size;
    logic [OFS_W-1:0]  addr;
    logic              cfg_idx;
    logic [USED_W-1:0] cfg_val;
    logic              known;     // result typed in below
    result_t           res;
  } step_row_t;

  localparam result_t NO_EXP = '{ST_OK, '0, '0};

  localparam step_row_t DIRECTED_STEPS [29] = '{
    // smallest block, wrong free, good free, free on empty stack, unused mode
    '{ROW_REQ, MODE_ALLOC, 16'd0, 16'hFFFF, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd4, 17'd4}},
    '{ROW_REQ, MODE_FREE, 16'hFFFF, 16'd8, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_NOT_TOP, 16'd0, 17'd4}},
    '{ROW_REQ, MODE_FREE, 16'd0, 16'd4, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd0, 17'd0}},
    '{ROW_REQ, MODE_FREE, 16'd0, 16'd4, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_NOT_TOP, 16'd0, 17'd0}},
    '{ROW_REQ, MODE_NOP, 16'hFFFF, 16'hFFFF, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd0, 17'd0}},
    // largest request overflows; exact fill of the pool; then no room left
    '{ROW_REQ, MODE_ALLOC, 16'd65535, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_NO_SPACE, 16'd0, 17'd0}},
    '{ROW_REQ, MODE_ALLOC, 16'd65532, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd4, 17'd65536}},
    '{ROW_REQ, MODE_ALLOC, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_NO_SPACE, 16'd0, 17'd65536}},
    '{ROW_REQ, MODE_FREE, 16'd0, 16'd4, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd0, 17'd0}},
    // byte alignment
    '{ROW_CFG, MODE_NOP, 16'd0, 16'd0, CFG_ALIGN_LOG2, 17'd0, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_ALLOC, 16'd1, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd4, 17'd5}},
    '{ROW_REQ, MODE_ALLOC, 16'd65526, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_CLEAR, 16'hFFFF, 16'hFFFF, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd0, 17'd0}},
    // alignment code 7 acts as 64-byte blocks
    '{ROW_CFG, MODE_NOP, 16'd0, 16'd0, CFG_ALIGN_LOG2, 17'd7, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_ALLOC, 16'd5, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd4, 17'd64}},
    '{ROW_REQ, MODE_ALLOC, 16'd60, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_FREE, 16'd0, 16'd68, CFG_POOL_BYTES, 17'd0, 1'b0, NO_EXP},
    // empty pool refuses an allocation; clear then empties the stack
    '{ROW_CFG, MODE_NOP, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_ALLOC, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_NO_SPACE, 16'd0, 17'd64}},
    '{ROW_REQ, MODE_CLEAR, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd0, 17'd0}},
    // oversized pool clamps; zero-size block at the pool end wraps its payload
    '{ROW_CFG, MODE_NOP, 16'd0, 16'd0, CFG_POOL_BYTES, 17'h1FFFF, 1'b0, NO_EXP},
    '{ROW_CFG, MODE_NOP, 16'd0, 16'd0, CFG_ALIGN_LOG2, 17'd2, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_ALLOC, 16'd65528, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_OK, 16'd4, 17'd65532}},
    '{ROW_REQ, MODE_ALLOC, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_FREE, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_FREE, 16'd0, 16'd4, CFG_POOL_BYTES, 17'd0, 1'b0, NO_EXP},
    // one-byte pool
    '{ROW_CFG, MODE_NOP, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd1, 1'b0, NO_EXP},
    '{ROW_REQ, MODE_ALLOC, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd0, 1'b1,
      '{ST_NO_SPACE, 16'd0, 17'd0}},
    '{ROW_CFG, MODE_NOP, 16'd0, 16'd0, CFG_POOL_BYTES, 17'd65536, 1'b0, NO_EXP}
  };

  stack_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .req_size_i   (req_size_i),
    .addr_i       (addr_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .addr_out_o   (addr_out_o),
    .used_bytes_o (used_bytes_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Answer of the allocator to one request; updates the shadow pool
  function automatic result_t apply_request(mode_e m, logic [OFS_W-1:0] sz,
                                            logic [OFS_W-1:0] ad);
    int unsigned limit;
    int unsigned shift;
    int unsigned mask;
    int unsigned blk;
    result_t     r;
    r.status   = ST_OK;
    r.addr_out = '0;
    case (m)
      MODE_ALLOC: begin
        limit = (cfg_pool > POOL_MAX) ? POOL_MAX : cfg_pool;
        shift = (cfg_align > ALIGN_MAX) ? ALIGN_MAX : cfg_align;
        mask  = (32'd1 << shift) - 1;
        blk   = (sz + HEADER_BYTES + mask) & ~mask;
        if (stack_depth >= MAX_BLOCKS) begin
          r.status = ST_STACK_FULL;
        end else if (pool_top + blk > limit) begin
          r.status = ST_NO_SPACE;
        end else begin
          block_base[stack_depth] = pool_top;
          stack_depth++;
          r.addr_out = OFS_W'(pool_top + HEADER_BYTES);
          pool_top  += blk;
        end
      end
      MODE_FREE: begin
        // only the payload of the topmost block pops it
        if (stack_depth != 0 &&
            OFS_W'(block_base[stack_depth-1] + HEADER_BYTES) == ad) begin
          stack_depth--;
          pool_top = block_base[stack_depth];
        end else begin
          r.status = ST_NOT_TOP;
        end
      end
      MODE_CLEAR: begin
        pool_top    = 0;
        stack_depth = 0;
      end
      default: ;
    endcase
    r.used_bytes = USED_W'(pool_top);
    return r;
  endfunction

  // Offer one request and hold it until the handshake
  task automatic send_req(mode_e m, logic [OFS_W-1:0] sz, logic [OFS_W-1:0] ad,
                          logic known = 1'b0, result_t fixed_res = NO_EXP);
    result_t res;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    res = apply_request(m, sz, ad);
    awaited_results.push_back(known ? fixed_res : res);
    in_valid_i <= 1'b1;
    mode_i     <= m;
    req_size_i <= sz;
    addr_i     <= ad;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Let every outstanding result drain, then idle the request side
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [USED_W-1:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POOL_BYTES) cfg_pool = val;
    else cfg_align = val[ALIGN_W-1:0];
  endtask

  // Random request mix; frees mostly target the live top block
  task automatic run_mix(int unsigned n, int unsigned alloc_pct, int unsigned free_pct,
                         int unsigned clear_pct, int unsigned max_size,
                         int unsigned big_pct);
    int unsigned      pick;
    logic [OFS_W-1:0] sz;
    logic [OFS_W-1:0] ad;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      sz   = ($urandom_range(0, 99) < big_pct) ? OFS_W'($urandom)
                                               : OFS_W'($urandom_range(0, max_size));
      ad   = OFS_W'($urandom);
      if (pick < alloc_pct) begin
        send_req(MODE_ALLOC, sz, ad);
      end else if (pick < alloc_pct + free_pct) begin
        if (stack_depth != 0 && $urandom_range(0, 9) < 7)
          ad = OFS_W'(block_base[stack_depth-1] + HEADER_BYTES);
        else if (stack_depth != 0 && $urandom_range(0, 1) == 1)
          ad = OFS_W'(block_base[$urandom_range(0, stack_depth-1)] + HEADER_BYTES);
        send_req(MODE_FREE, sz, ad);
      end else if (pick < alloc_pct + free_pct + clear_pct) begin
        send_req(MODE_CLEAR, sz, ad);
      end else begin
        send_req(MODE_NOP, sz, ad);
      end
    end
  endtask

  // Result side: random back-pressure, compare against the oldest prediction
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: status %0d addr_out %0d used %0d",
               status_o, addr_out_o, used_bytes_o);
        n_fail++;
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          n_fail++;
        end
        if (addr_out_o !== want.addr_out) begin
          $error("addr_out: expected %0d, got %0d", want.addr_out, addr_out_o);
          n_fail++;
        end
        if (used_bytes_o !== want.used_bytes) begin
          $error("used_bytes: expected %0d, got %0d", want.used_bytes, used_bytes_o);
          n_fail++;
        end
      end
    end
    out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  initial begin : stimulus
    step_row_t row;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIRECTED_STEPS[i]) begin
      row = DIRECTED_STEPS[i];
      if (row.kind == ROW_CFG) write_reg(row.cfg_idx, row.cfg_val);
      else send_req(row.mode, row.size, row.addr, row.known, row.res);
    end

    // default geometry, general mix
    run_mix(250, 50, 35, 5, 300, 5);

    // fill the block stack until it overflows, no idling on either side
    write_reg(CFG_ALIGN_LOG2, 17'd0);
    steady = 1'b1;
    send_req(MODE_CLEAR, OFS_W'($urandom), OFS_W'($urandom));
    while (stack_depth < MAX_BLOCKS) run_mix(1, 90, 8, 0, 15, 0);
    run_mix(40, 70, 25, 0, 15, 0);
    steady = 1'b0;

    // small pools: frequent overflow
    repeat (6) begin
      write_reg(CFG_POOL_BYTES, USED_W'($urandom_range(0, 1200)));
      write_reg(CFG_ALIGN_LOG2, USED_W'($urandom_range(0, 7)));
      run_mix(40, 60, 30, 5, 100, 5);
    end

    // any pool size, large requests
    repeat (4) begin
      write_reg(CFG_POOL_BYTES, USED_W'($urandom_range(0, 131071)));
      write_reg(CFG_ALIGN_LOG2, USED_W'($urandom_range(0, 7)));
      run_mix(40, 55, 35, 3, 4000, 20);
    end

    // extremes of both registers
    write_reg(CFG_POOL_BYTES, 17'd65536);
    write_reg(CFG_ALIGN_LOG2, 17'd6);
    run_mix(30, 60, 30, 5, 200, 10);
    write_reg(CFG_POOL_BYTES, 17'd1);
    write_reg(CFG_ALIGN_LOG2, 17'd0);
    run_mix(10, 70, 20, 5, 10, 0);

    settle();
    if (n_fail == 0) begin
      $display("** stack_allocator: PASSED **");
    end else begin
      $display("** stack_allocator: FAILED **");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("** stack_allocator: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sa_pkg.sv
hdl/sa_stack_mem.sv
hdl/sa_ctrl.sv
hdl/stack_allocator.sv
tb/stack_allocator_tb.sv
